>>> rtl/jpd_pkg.sv
`timescale 1ns / 1ps

package jpd_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_DEADBAND    = 3'd0;
  localparam logic [2:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [2:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] CFG_MIN_DRIVE   = 3'd3;
  localparam logic [2:0] CFG_PWM_PERIOD  = 3'd4;
  localparam logic [2:0] CFG_INVERT_MASK = 3'd5;

  // register widths
  localparam int DEADBAND_W = 15;
  localparam int GAIN_W     = 8;
  localparam int DRIVE_W    = 16;
  localparam int PERIOD_W   = 16;
  localparam int MASK_W     = 4;
  localparam int CFG_W      = 16;

  // register reset values
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST    = 15'd128;
  localparam logic [GAIN_W-1:0]     PROP_GAIN_RST   = 8'd30;
  localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST  = 8'd20;
  localparam logic [DRIVE_W-1:0]    MIN_DRIVE_RST   = 16'd800;
  localparam logic [PERIOD_W-1:0]   PWM_PERIOD_RST  = 16'd4096;
  localparam logic [MASK_W-1:0]     INVERT_MASK_RST = 4'd3;

  // word fields
  localparam int MOTOR_W  = 2;
  localparam int ANGLE_W  = 17;
  localparam int TARGET_W = 16;

  // angle constants in whole degrees
  localparam int HALF_TURN_DEG = 180;
  localparam int FULL_TURN_DEG = 360;

  // error width covering every wrap for frac bits up to 10
  localparam int ERR_W = 20;

endpackage

>>> rtl/jpd_ram.sv
`timescale 1ns / 1ps

module jpd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/joint_pd_drive_with_deadband_core.sv
`timescale 1ns / 1ps

// channel | dir | handshake              | payload (lowest bit first)
// in      | in  | in_tvalid / in_tready  | tuser: motor_index[1:0]
//         |     |                        | tdata: measured_angle[16:0], target_angle[32:17]
// out     | out | out_tvalid / out_tready| tuser: motor_out[1:0], arrived[2]
//         |     |                        | tdata: duty_value[15:0]
// cfg     | in  | cfg_wr_en              | cfg_index[2:0], cfg_data[15:0]
//
// one word per cycle without back-pressure; registers: stage 1, stage 2, output
// stages: error + last-error read, two gain multiplies, clamp and saturate
// last_error lives in a one-port-read RAM; a same-motor word right behind takes
// the forwarded error; per-motor valid bits make unwritten entries read as zero
// synchronous active-low reset loads config reset values, clears valid bits and the pipeline
// each stage holds only when the one after it is full and stalled

module joint_pd_drive_with_deadband_core #(
  parameter int MOTOR_COUNT     = 4,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // measured_angle[16:0], target_angle[32:17], zero pad
  input  logic [1:0]  in_tuser,   // motor_index[1:0]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // duty_value[15:0]
  output logic [2:0]  out_tuser,  // motor_out[1:0], arrived[2]
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ERR_W  = jpd_pkg::ERR_W;
  localparam int AW     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int P_W    = ERR_W + jpd_pkg::GAIN_W + 1;
  localparam int D_W    = ERR_W + jpd_pkg::GAIN_W + 2;
  localparam int PD_W   = D_W + 1;
  localparam int HALF_TURN_I = jpd_pkg::HALF_TURN_DEG * (1 << ANGLE_FRAC_BITS);
  localparam int FULL_TURN_I = jpd_pkg::FULL_TURN_DEG * (1 << ANGLE_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] HALF_TURN = ERR_W'(HALF_TURN_I);
  localparam logic signed [ERR_W-1:0] FULL_TURN = ERR_W'(FULL_TURN_I);

  // configuration registers
  logic [jpd_pkg::DEADBAND_W-1:0] deadband_r;
  logic [jpd_pkg::GAIN_W-1:0]     prop_gain_r;
  logic [jpd_pkg::GAIN_W-1:0]     deriv_gain_r;
  logic [jpd_pkg::DRIVE_W-1:0]    min_drive_r;
  logic [jpd_pkg::PERIOD_W-1:0]   pwm_period_r;
  logic [jpd_pkg::MASK_W-1:0]     invert_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r    <= jpd_pkg::DEADBAND_RST;
      prop_gain_r   <= jpd_pkg::PROP_GAIN_RST;
      deriv_gain_r  <= jpd_pkg::DERIV_GAIN_RST;
      min_drive_r   <= jpd_pkg::MIN_DRIVE_RST;
      pwm_period_r  <= jpd_pkg::PWM_PERIOD_RST;
      invert_mask_r <= jpd_pkg::INVERT_MASK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jpd_pkg::CFG_DEADBAND:    deadband_r    <= cfg_data[jpd_pkg::DEADBAND_W-1:0];
        jpd_pkg::CFG_PROP_GAIN:   prop_gain_r   <= cfg_data[jpd_pkg::GAIN_W-1:0];
        jpd_pkg::CFG_DERIV_GAIN:  deriv_gain_r  <= cfg_data[jpd_pkg::GAIN_W-1:0];
        jpd_pkg::CFG_MIN_DRIVE:   min_drive_r   <= cfg_data[jpd_pkg::DRIVE_W-1:0];
        jpd_pkg::CFG_PWM_PERIOD:  pwm_period_r  <= cfg_data[jpd_pkg::PERIOD_W-1:0];
        jpd_pkg::CFG_INVERT_MASK: invert_mask_r <= cfg_data[jpd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_v_r, s2_v_r, out_v_r;
  logic adv_out, adv2, adv1, in_acc;

  assign adv_out   = !out_v_r || out_tready;
  assign adv2      = !s2_v_r || adv_out;
  assign adv1      = !s1_v_r || adv2;
  assign in_tready = adv1;
  assign in_acc    = in_tvalid && adv1;

  // input decode, wrap and error
  logic [jpd_pkg::MOTOR_W-1:0] in_motor;
  logic signed [ERR_W-1:0]     q_ext, q_wrap, tgt_ext, e_raw, e_in;
  logic                        in_inr;
  logic [AW-1:0]               in_addr;

  assign in_motor = in_tuser;
  assign q_ext    = {{(ERR_W-jpd_pkg::ANGLE_W){in_tdata[16]}}, in_tdata[16:0]};
  assign tgt_ext  = {{(ERR_W-jpd_pkg::TARGET_W){in_tdata[32]}}, in_tdata[32:17]};
  assign in_inr   = (32'(in_motor) < 32'(MOTOR_COUNT));
  assign in_addr  = AW'(in_motor);

  always_comb begin
    if (q_ext > HALF_TURN) begin
      q_wrap = q_ext - FULL_TURN;
    end else if (q_ext < -HALF_TURN) begin
      q_wrap = q_ext + FULL_TURN;
    end else begin
      q_wrap = q_ext;
    end
    e_raw = tgt_ext - q_wrap;
    e_in  = invert_mask_r[in_motor] ? -e_raw : e_raw;
  end

  // last_error store
  logic                    wr_en;
  logic [AW-1:0]           s1_addr;
  logic [ERR_W-1:0]        ram_q;
  logic [MOTOR_COUNT-1:0]  vld_r;
  logic [jpd_pkg::MOTOR_W-1:0] s1_motor_r;
  logic signed [ERR_W-1:0] s1_e_r;
  logic                    s1_inr_r;
  logic                    fwd_hit_r, fwd_hit_nxt;
  logic signed [ERR_W-1:0] fwd_e_r;

  assign s1_addr = AW'(s1_motor_r);
  assign wr_en   = s1_v_r && adv2 && s1_inr_r;

  jpd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MOTOR_COUNT)
  ) u_last_err (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (s1_e_r),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (ram_q)
  );

  // entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_addr] <= 1'b1;
    end
  end

  // forward the error written in the same cycle as the read
  assign fwd_hit_nxt = wr_en && in_inr && (s1_addr == in_addr);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_hit_r <= fwd_hit_nxt;
      fwd_e_r   <= s1_e_r;
    end
  end

  // stage 1: error held, previous error picked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_motor_r <= in_motor;
      s1_e_r     <= e_in;
      s1_inr_r   <= in_inr;
    end
  end

  logic signed [ERR_W-1:0] prev_e, db_ext;
  logic signed [ERR_W:0]   diff;
  logic signed [P_W-1:0]   p_prod;
  logic signed [D_W-1:0]   d_prod;
  logic                    s1_inside, s1_neg;

  always_comb begin
    if (!s1_inr_r) begin
      prev_e = '0;
    end else if (fwd_hit_r) begin
      prev_e = fwd_e_r;
    end else if (vld_r[s1_addr]) begin
      prev_e = $signed(ram_q);
    end else begin
      prev_e = '0;
    end
    diff   = {s1_e_r[ERR_W-1], s1_e_r} - {prev_e[ERR_W-1], prev_e};
    p_prod = P_W'($signed({1'b0, prop_gain_r})) * P_W'(s1_e_r);
    d_prod = D_W'($signed({1'b0, deriv_gain_r})) * D_W'(diff);
  end

  // deadband compare
  assign db_ext    = $signed({{(ERR_W-jpd_pkg::DEADBAND_W){1'b0}}, deadband_r});
  assign s1_inside = (s1_e_r > -db_ext) && (s1_e_r < db_ext);
  assign s1_neg    = (s1_e_r <= -db_ext);

  // stage 2: products registered
  logic [jpd_pkg::MOTOR_W-1:0] s2_motor_r;
  logic                        s2_inside_r, s2_neg_r;
  logic signed [P_W-1:0]       s2_p_r;
  logic signed [D_W-1:0]       s2_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_motor_r  <= s1_motor_r;
      s2_inside_r <= s1_inside;
      s2_neg_r    <= s1_neg;
      s2_p_r      <= p_prod;
      s2_d_r      <= d_prod;
    end
  end

  // sum, floor shift, minimum drive, duty and saturation
  logic signed [PD_W-1:0] pd_sum, pd_sh, pd_clamp, md_ext, half_ext, per_ext;
  logic signed [PD_W:0]   duty_full;
  logic [jpd_pkg::PERIOD_W-1:0] duty_nxt;

  assign md_ext   = $signed({{(PD_W-jpd_pkg::DRIVE_W){1'b0}}, min_drive_r});
  assign half_ext = $signed({{(PD_W-jpd_pkg::PERIOD_W+1){1'b0}},
                             pwm_period_r[jpd_pkg::PERIOD_W-1:1]});
  assign per_ext  = $signed({{(PD_W-jpd_pkg::PERIOD_W){1'b0}}, pwm_period_r});

  always_comb begin
    pd_sum = {{(PD_W-P_W){s2_p_r[P_W-1]}}, s2_p_r} + {s2_d_r[D_W-1], s2_d_r};
    pd_sh  = pd_sum >>> ANGLE_FRAC_BITS;
    if (s2_neg_r) begin
      pd_clamp = (pd_sh > -md_ext) ? -md_ext : pd_sh;
    end else begin
      pd_clamp = (pd_sh < md_ext) ? md_ext : pd_sh;
    end
    duty_full = {half_ext[PD_W-1], half_ext} - {pd_clamp[PD_W-1], pd_clamp};
    if (s2_inside_r) begin
      duty_nxt = pwm_period_r >> 1;
    end else if (duty_full < 0) begin
      duty_nxt = '0;
    end else if (duty_full > {per_ext[PD_W-1], per_ext}) begin
      duty_nxt = pwm_period_r;
    end else begin
      duty_nxt = duty_full[jpd_pkg::PERIOD_W-1:0];
    end
  end

  // output register
  logic [jpd_pkg::MOTOR_W-1:0]  out_motor_r;
  logic                         out_arr_r;
  logic [jpd_pkg::PERIOD_W-1:0] out_duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv_out) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s2_v_r) begin
      out_motor_r <= s2_motor_r;
      out_arr_r   <= s2_inside_r;
      out_duty_r  <= duty_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_duty_r;
  assign out_tuser  = {out_arr_r, out_motor_r};

  // checks
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= pwm_period_r))
    else $error("duty above period");

  a_arrived_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tdata == (pwm_period_r >> 1)))
    else $error("arrived word without half period");

  a_write_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_v_r && s1_inr_r && (!s2_v_r || adv_out)))
    else $error("last_error written by a held or empty stage");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s2_v_r && out_v_r && !out_tready))
    else $error("input stalled with room in the pipeline");

endmodule
